// ===== hw/rtl/assert_macros.svh =====
// assertion helper macros for the allocator rtl
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define AST_CHECK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion check failed");
// expression must never be true outside reset
`define AST_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion never failed");
`else
`define AST_CHECK(label, clk, rst, prop)
`define AST_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== hw/rtl/bba_pkg.sv =====
// shared types and constants for the block bitmap allocator
// no dependencies; used by block_bitmap_allocator_core
package bba_pkg;

   // allocator geometry
   localparam int BLOCKS      = 128;
   localparam int RESERVED    = 10;
   localparam int MAX_REQUEST = 32;

   // bitmap is held as rows of flags
   localparam int ROW_W  = 16;
   localparam int ROWS   = BLOCKS / ROW_W;
   localparam int ROW_AW = $clog2(ROWS);
   localparam int COL_AW = $clog2(ROW_W);

   // field widths
   localparam int INDEX_W  = 7;
   localparam int COUNT_W  = 6;
   localparam int STATUS_W = 2;
   localparam int FREE_W   = 8;

   // free count after reset
   localparam logic [FREE_W-1:0] FREE_RESET = FREE_W'(BLOCKS - RESERVED);

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_WASFREE = 2'd2;

   typedef struct packed {
      logic               operation;
      logic [COUNT_W-1:0] count;
      logic [INDEX_W-1:0] block_index;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  granted_index;
      logic [STATUS_W-1:0] status;
      logic                last;
      logic [FREE_W-1:0]   free_blocks;
   } rsp_type;

   // reset contents of one bitmap row: reserved blocks are marked used
   function automatic logic [ROW_W-1:0] row_reset(input int row);
      logic [ROW_W-1:0] bits;
      bits = '0;
      for (int c = 0; c < ROW_W; c++) begin
         if (row * ROW_W + c < RESERVED) begin
            bits[c] = 1'b1;
         end
      end
      return bits;
   endfunction

endpackage

// ===== hw/rtl/block_bitmap_allocator_core.sv =====
// first-fit block allocator: bitmap rows, scan sequencer and result register
// depends on bba_pkg and assert_macros.svh
//
// Keeps a used/free flag for each of 128 blocks (the lowest ten used after reset)
// and a free count. A request is taken when start is high and busy is low. An
// allocate that cannot be met (count zero, above 32, or above the free count)
// is answered in the next cycle with a single no-space result, and busy
// stays low. Otherwise the sequencer walks the bitmap one 16-bit row per cycle
// through a single lowest-free-bit finder: each cycle it either claims one block
// and emits its index, or steps to the next row. An allocate of N blocks thus
// keeps busy high until its Nth block is claimed, and its first result is
// registered at the first claim in the alloc state. A free keeps busy high for
// one cycle and its result is registered in the free state. Each result is
// shown on rsp for exactly one cycle with rsp_valid high and cannot be held
// off, so the receiver must take one result per cycle.
`include "assert_macros.svh"

module block_bitmap_allocator_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bba_pkg::req_type req,
   output logic             rsp_valid,
   output bba_pkg::rsp_type rsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_FREE
   } state_type;

   state_type                          state_ff;
   logic [bba_pkg::ROW_W-1:0]          map_ff [bba_pkg::ROWS];
   logic [bba_pkg::FREE_W-1:0]         free_total_ff;
   logic [bba_pkg::ROW_AW-1:0]         row_ff;
   logic [bba_pkg::COUNT_W-1:0]        left_ff;
   bba_pkg::req_type                   req_ff;
   logic                               rsp_valid_ff;
   bba_pkg::rsp_type                   rsp_ff;

   logic [bba_pkg::ROW_W-1:0]          scan_row;
   logic                               zero_found;
   logic [bba_pkg::COL_AW-1:0]         zero_col;
   logic                               alloc_bad;
   logic [bba_pkg::ROW_AW-1:0]         free_row;
   logic [bba_pkg::COL_AW-1:0]         free_col;
   logic                               free_in_range;
   logic                               free_used;

   // lowest clear bit of the row under scan
   always_comb begin
      scan_row   = map_ff[row_ff];
      zero_found = 1'b0;
      zero_col   = '0;
      for (int c = bba_pkg::ROW_W - 1; c >= 0; c--) begin
         if (!scan_row[c]) begin
            zero_found = 1'b1;
            zero_col   = bba_pkg::COL_AW'(c);
         end
      end
   end

   // allocate request that cannot be met
   assign alloc_bad = (req.count == '0) ||
                      (int'(req.count) > bba_pkg::MAX_REQUEST) ||
                      (bba_pkg::FREE_W'(req.count) > free_total_ff);

   // release target of the held request
   assign free_row      = req_ff.block_index[bba_pkg::COL_AW +: bba_pkg::ROW_AW];
   assign free_col      = req_ff.block_index[bba_pkg::COL_AW-1:0];
   assign free_in_range = int'(req_ff.block_index) < bba_pkg::BLOCKS;
   assign free_used     = free_in_range && map_ff[free_row][free_col];

   // sequencer, bitmap and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         free_total_ff <= bba_pkg::FREE_RESET;
         for (int r = 0; r < bba_pkg::ROWS; r++) begin
            map_ff[r] <= bba_pkg::row_reset(r);
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff <= req;
                  if (req.operation == bba_pkg::OP_ALLOC) begin
                     if (alloc_bad) begin
                        rsp_valid_ff         <= 1'b1;
                        rsp_ff.granted_index <= '0;
                        rsp_ff.status        <= bba_pkg::STATUS_NOSPACE;
                        rsp_ff.last          <= 1'b1;
                        rsp_ff.free_blocks   <= free_total_ff;
                     end else begin
                        row_ff   <= '0;
                        left_ff  <= req.count;
                        state_ff <= ST_ALLOC;
                     end
                  end else begin
                     state_ff <= ST_FREE;
                  end
               end
            end
            ST_ALLOC: begin
               if (zero_found) begin
                  // claim one block
                  map_ff[row_ff][zero_col] <= 1'b1;
                  free_total_ff            <= free_total_ff - bba_pkg::FREE_W'(1);
                  left_ff                  <= left_ff - bba_pkg::COUNT_W'(1);
                  rsp_valid_ff             <= 1'b1;
                  rsp_ff.granted_index     <= bba_pkg::INDEX_W'({row_ff, zero_col});
                  rsp_ff.status            <= bba_pkg::STATUS_OK;
                  rsp_ff.last              <= (left_ff == bba_pkg::COUNT_W'(1));
                  rsp_ff.free_blocks       <= free_total_ff - bba_pkg::FREE_W'(1);
                  if (left_ff == bba_pkg::COUNT_W'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  row_ff <= row_ff + bba_pkg::ROW_AW'(1);
               end
            end
            ST_FREE: begin
               rsp_valid_ff         <= 1'b1;
               rsp_ff.granted_index <= req_ff.block_index;
               rsp_ff.last          <= 1'b1;
               if (free_used) begin
                  map_ff[free_row][free_col] <= 1'b0;
                  free_total_ff              <= free_total_ff + bba_pkg::FREE_W'(1);
                  rsp_ff.status              <= bba_pkg::STATUS_OK;
                  rsp_ff.free_blocks         <= free_total_ff + bba_pkg::FREE_W'(1);
               end else begin
                  rsp_ff.status      <= bba_pkg::STATUS_WASFREE;
                  rsp_ff.free_blocks <= free_total_ff;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // the scan never runs past the last row without finding a free block
   `AST_NEVER(a_scan_in_bounds, clock, reset,
      (state_ff == ST_ALLOC) && !zero_found &&
      (row_ff == bba_pkg::ROW_AW'(bba_pkg::ROWS - 1)))
   // an active allocation always has blocks left to claim
   `AST_NEVER(a_alloc_left, clock, reset, (state_ff == ST_ALLOC) && (left_ff == '0))
   // each claim lowers the free count by one
   `AST_CHECK(a_claim_count, clock, reset,
      ((state_ff == ST_ALLOC) && zero_found) |=>
      (free_total_ff == $past(free_total_ff) - bba_pkg::FREE_W'(1)))
   // free count never exceeds the number of blocks
   `AST_NEVER(a_free_bound, clock, reset,
      free_total_ff > bba_pkg::FREE_W'(bba_pkg::BLOCKS))
   // a no-space answer is always the final result
   `AST_CHECK(a_nospace_last, clock, reset,
      (rsp_valid_ff && (rsp_ff.status == bba_pkg::STATUS_NOSPACE)) |-> rsp_ff.last)

endmodule

// ===== dv/bba_grant_checker.sv =====
// grant checker for the block bitmap allocator: predicts and compares every result
// depends on bba_pkg; instantiated beside the core by block_bitmap_allocator_core_tb
`timescale 1ns / 1ps

module bba_grant_checker
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req,
   input  logic        rsp_valid,
   input  rsp_type     rsp,
   output int unsigned error_count,
   output int unsigned pending_grants
);

   // shadow of the allocator state
   logic [BLOCKS-1:0] block_used;
   logic [FREE_W-1:0] free_count;

   // results still owed by the core, oldest first
   rsp_type expected_grants[$];

   int unsigned errors;

   assign error_count = errors;

   function automatic rsp_type grant_of(input logic [INDEX_W-1:0] idx,
                                        input logic [STATUS_W-1:0] st,
                                        input logic lst,
                                        input logic [FREE_W-1:0] fb);
      return {idx, st, lst, fb};
   endfunction

   // append one owed result at the tail
   task automatic queue_grant(input rsp_type g);
      expected_grants = {expected_grants, g};
   endtask

   // work out the results of one request and update the shadow state
   task automatic predict_grants(input req_type r);
      int claimed;
      claimed = 0;
      if (r.operation == OP_ALLOC) begin
         // zero, oversized and unfittable counts all get one no-space answer
         if (r.count == '0 || r.count > MAX_REQUEST || r.count > free_count) begin
            queue_grant(grant_of('0, STATUS_NOSPACE, 1'b1, free_count));
         end else begin
            // first fit: lowest free blocks in ascending order
            for (int i = 0; i < BLOCKS && claimed < r.count; i++) begin
               if (!block_used[i]) begin
                  block_used[i] = 1'b1;
                  free_count    = free_count - 1'b1;
                  queue_grant(grant_of(INDEX_W'(i), STATUS_OK,
                                       claimed + 1 == r.count, free_count));
                  claimed++;
               end
            end
         end
      end else if (!block_used[r.block_index]) begin
         // release of a block that is not held changes nothing
         queue_grant(grant_of(r.block_index, STATUS_WASFREE, 1'b1, free_count));
      end else begin
         block_used[r.block_index] = 1'b0;
         free_count                = free_count + 1'b1;
         queue_grant(grant_of(r.block_index, STATUS_OK, 1'b1, free_count));
      end
   endtask

   // field by field comparison against the oldest expectation
   task automatic compare_grant(input rsp_type got);
      rsp_type want;
      if (expected_grants.size() == 0) begin
         $error("unexpected result: index %0d status %0d last %0d free %0d",
                got.granted_index, got.status, got.last, got.free_blocks);
         errors++;
      end else begin
         want = expected_grants.pop_front();
         if (got.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, got %0d",
                   want.granted_index, got.granted_index);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
         if (got.free_blocks !== want.free_blocks) begin
            $error("free_blocks: expected %0d, got %0d",
                   want.free_blocks, got.free_blocks);
            errors++;
         end
      end
   endtask

   // results are checked before the request taken at the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         block_used = '0;
         for (int i = 0; i < RESERVED; i++) begin
            block_used[i] = 1'b1;
         end
         free_count = FREE_RESET;
         expected_grants.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            compare_grant(rsp);
         end
         if (start === 1'b1 && busy === 1'b0) begin
            predict_grants(req);
         end
      end
      pending_grants <= expected_grants.size();
   end

endmodule

// ===== dv/block_bitmap_allocator_core_tb.sv =====
// testbench top for block_bitmap_allocator_core: clock, reset, request stimulus, verdict
// depends on bba_pkg, block_bitmap_allocator_core and bba_grant_checker
`timescale 1ns / 1ps

module block_bitmap_allocator_core_tb;
   import bba_pkg::*;

   localparam int RANDOM_REQUESTS = 100;
   localparam int QUIET_TAIL      = 20;
   localparam int SETTLE_CYCLES   = 48;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req   = '0;
   logic        rsp_valid;
   rsp_type     rsp;
   int unsigned error_count;
   int unsigned pending_grants;

   block_bitmap_allocator_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   bba_grant_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req            (req),
      .rsp_valid      (rsp_valid),
      .rsp            (rsp),
      .error_count    (error_count),
      .pending_grants (pending_grants)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // unused fields carry random bits
   function automatic req_type alloc_req(input int n);
      return {OP_ALLOC, COUNT_W'(n), INDEX_W'($urandom_range(0, 127))};
   endfunction

   function automatic req_type free_req(input int idx);
      return {OP_FREE, COUNT_W'($urandom_range(0, 63)), INDEX_W'(idx)};
   endfunction

   // present a request and hold it until the core takes it
   task automatic issue(input req_type r);
      start <= 1'b1;
      req   <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop sending until every owed result has come back
   task automatic drain_grants();
      start <= 1'b0;
      @(posedge clock);
      while (pending_grants != 0) @(posedge clock);
   endtask

   // mostly small allocations and frees near the low end where grants land
   function automatic req_type random_request();
      int sel;
      int pick;
      sel  = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      if (sel < 38) begin
         if (pick < 7) begin
            return alloc_req($urandom_range(1, 8));
         end else if (pick < 9) begin
            return alloc_req($urandom_range(9, 32));
         end else if ($urandom_range(0, 1) == 0) begin
            return alloc_req(0);
         end else begin
            return alloc_req($urandom_range(33, 63));
         end
      end else if (pick < 6) begin
         return free_req($urandom_range(0, 63));
      end else begin
         return free_req($urandom_range(0, 127));
      end
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero, oversized and all-ones counts
      issue(alloc_req(0));
      issue(alloc_req(33));
      issue(alloc_req(63));
      // already free, including the top index
      issue(free_req(127));
      issue(free_req(10));
      // reserved blocks may be released
      issue(free_req(0));
      issue(free_req(9));
      hold_off(3);
      // first fit picks up the released reserved blocks first
      issue(alloc_req(1));
      issue(alloc_req(32));
      issue(alloc_req(32));
      issue(alloc_req(32));
      // more than is free, then exactly what is free
      issue(alloc_req(32));
      issue(alloc_req(23));
      issue(alloc_req(1));
      // release and reclaim across the map
      issue(free_req(127));
      issue(free_req(127));
      issue(alloc_req(1));
      issue(free_req(64));
      issue(free_req(3));
      issue(alloc_req(2));
      issue(free_req(5));
      issue(alloc_req(32));
      drain_grants();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         issue(random_request());
         if (n == RANDOM_REQUESTS / 2) begin
            drain_grants();
         end else if (n < RANDOM_REQUESTS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            hold_off($urandom_range(1, 11));
         end
      end

      drain_grants();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #1ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
